// ===== rtl/core/second_greater_element_finder_core_assert.svh =====
// Assertion macros for the second greater element finder core
`ifndef SECOND_GREATER_ELEMENT_FINDER_CORE_ASSERT_SVH
`define SECOND_GREATER_ELEMENT_FINDER_CORE_ASSERT_SVH
// Immediate consequence check
`define SGE_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
// Next-cycle consequence check
`define SGE_ASSERT_NXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`endif

// ===== rtl/core/sgef_pkg.sv =====
// Package with constants, types and state codes of the second greater element finder
`default_nettype none
package sgef_pkg;
  localparam int MAX_LEN = 32;
  localparam int VALUE_BITS = 32;
  localparam int IDX_BITS = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int PTR_BITS = $clog2(MAX_LEN + 1);
  localparam int POS_BITS = 6;
  localparam int SAMPLE_BITS = 32;

  typedef enum logic [3:0] {
    ST_IDLE, ST_S2_RD, ST_S2_WT, ST_S2_CMP, ST_EMIT_RES, ST_EMIT_HOLD,
    ST_S1_RD, ST_S1_WT, ST_S1_CMP, ST_PUSH, ST_MV_CHK, ST_MOVE,
    ST_FLUSH, ST_EMIT_FL, ST_OVF
  } state_t;

  typedef struct packed {
    logic load;
    logic rd_s2;
    logic rd_s1;
    logic pop_s2;
    logic pop_s1;
    logic push_new;
    logic move_one;
    logic flush_s2;
    logic flush_s1;
    logic out_load;
    logic out_found;
    logic out_ovf_only;
    logic out_last;
    logic clear_count;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic ovf;
    logic s2_empty;
    logic s1_empty;
    logic s2_one;
    logic s1_one;
    logic m_empty;
    logic greater;
    logic out_busy;
    logic hold_v;
  } status_t;
endpackage
`default_nettype wire

// ===== rtl/core/sgef_stream_if.sv =====
// Valid/ready channel interfaces for input and result transactions
`default_nettype none
interface sgef_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] sample;
  logic seq_end;
  modport source (output valid, sample, seq_end, input ready);
  modport sink (input valid, sample, seq_end, output ready);
endinterface

interface sgef_out_if;
  logic valid;
  logic ready;
  logic [5:0] position;
  logic signed [31:0] answer;
  logic found;
  logic run_end;
  logic seq_done;
  logic overflow;
  modport source (output valid, position, answer, found, run_end, seq_done, overflow,
    input ready);
  modport sink (input valid, position, answer, found, run_end, seq_done, overflow,
    output ready);
endinterface
`default_nettype wire

// ===== rtl/core/sgef_ram.sv =====
// Generic single-port-write RAM with registered read
`default_nettype none
module sgef_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/core/sgef_datapath.sv =====
// Datapath: value store, two wait stacks, move buffer and output register
`default_nettype none
module sgef_datapath
  import sgef_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire cmd_t    cmd,
  output status_t      sts,
  sgef_in_if.sink      in_ch,
  sgef_out_if.source   out_ch
);
  logic [VALUE_BITS-1:0] cur;
  logic                  last;
  logic [PTR_BITS-1:0]   p1, p2, pm, cnt;
  logic                  ovf;
  logic [IDX_BITS-1:0]   s1_rd, s2_rd, m_rd, s1_wa, s2_wa;
  logic [IDX_BITS-1:0]   s1_wd, s2_wd, v_ra;
  logic                  s1_we, s2_we, m_we;
  logic [VALUE_BITS-1:0] v_rd;
  logic                  sel1;
  logic                  ov_busy;
  logic [IDX_BITS-1:0]   hold_pos;
  logic                  hold_v;

  sgef_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_LEN)) u_val (
    .clk, .we(cmd.push_new), .waddr(cnt[IDX_BITS-1:0]), .wdata(cur),
    .raddr(v_ra), .rdata(v_rd));
  sgef_ram #(.WIDTH(IDX_BITS), .DEPTH(MAX_LEN)) u_s1 (
    .clk, .we(s1_we), .waddr(s1_wa), .wdata(s1_wd),
    .raddr(s1_wa - IDX_BITS'(1)), .rdata(s1_rd));
  sgef_ram #(.WIDTH(IDX_BITS), .DEPTH(MAX_LEN)) u_s2 (
    .clk, .we(s2_we), .waddr(s2_wa), .wdata(s2_wd),
    .raddr(s2_wa - IDX_BITS'(1)), .rdata(s2_rd));
  sgef_ram #(.WIDTH(IDX_BITS), .DEPTH(MAX_LEN)) u_m (
    .clk, .we(m_we), .waddr(pm[IDX_BITS-1:0]), .wdata(s1_rd),
    .raddr(pm[IDX_BITS-1:0] - IDX_BITS'(1)), .rdata(m_rd));

  assign s1_wa = p1[IDX_BITS-1:0];
  assign s2_wa = p2[IDX_BITS-1:0];
  assign s1_we = cmd.push_new && (p1 < PTR_BITS'(MAX_LEN));
  assign s1_wd = cnt[IDX_BITS-1:0];
  assign s2_we = cmd.move_one && (p2 < PTR_BITS'(MAX_LEN));
  assign s2_wd = m_rd;
  assign m_we  = cmd.pop_s1;
  assign v_ra  = sel1 ? s1_rd : s2_rd;
  assign sts.greater = ($signed(cur) > $signed(v_rd));
  assign sts.last = last;
  assign sts.ovf = ovf;
  assign sts.s1_empty = (p1 == '0);
  assign sts.s2_empty = (p2 == '0);
  assign sts.s1_one = (p1 == PTR_BITS'(1));
  assign sts.s2_one = (p2 == PTR_BITS'(1));
  assign sts.m_empty = (pm == '0);
  assign sts.out_busy = ov_busy;
  assign sts.hold_v = hold_v;
  assign in_ch.ready = cmd.load;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur <= VALUE_BITS'(in_ch.sample);
      last <= in_ch.seq_end;
    end
    if (cmd.rd_s1) sel1 <= 1'b1;
    if (cmd.rd_s2) sel1 <= 1'b0;
    if (cmd.pop_s2) hold_pos <= s2_rd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_v <= 1'b0;
    end else if (cmd.pop_s2) begin
      hold_v <= 1'b1;
    end else if (cmd.out_load && cmd.out_found) begin
      hold_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1 <= '0; p2 <= '0; pm <= '0; cnt <= '0; ovf <= 1'b0;
    end else begin
      if (cmd.load) ovf <= (cnt >= PTR_BITS'(MAX_LEN));
      if (cmd.pop_s2 || cmd.flush_s2) p2 <= p2 - PTR_BITS'(1);
      if (cmd.pop_s1 || cmd.flush_s1) p1 <= p1 - PTR_BITS'(1);
      if (cmd.pop_s1) pm <= pm + PTR_BITS'(1);
      if (cmd.push_new) begin
        cnt <= cnt + PTR_BITS'(1);
        if (s1_we) p1 <= p1 + PTR_BITS'(1);
      end
      if (cmd.move_one) begin
        pm <= pm - PTR_BITS'(1);
        if (s2_we) p2 <= p2 + PTR_BITS'(1);
      end
      if (cmd.clear_count) cnt <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov_busy <= 1'b0;
    end else if (cmd.out_load) begin
      ov_busy <= 1'b1;
    end else if (out_ch.ready) begin
      ov_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_ch.position <= cmd.out_ovf_only ? '0 :
        POS_BITS'(cmd.out_found ? hold_pos : (sel1 ? s1_rd : s2_rd));
      out_ch.answer <= cmd.out_ovf_only ? '0 : (cmd.out_found ?
        SAMPLE_BITS'($signed(cur)) : '1);
      out_ch.found <= cmd.out_found;
      out_ch.run_end <= cmd.out_last;
      out_ch.seq_done <= cmd.out_last && last;
      out_ch.overflow <= cmd.out_ovf_only || (ovf && !cmd.out_found);
    end
  end
  assign out_ch.valid = ov_busy;
endmodule
`default_nettype wire

// ===== rtl/core/sgef_ctrl.sv =====
// Controller state machine sequencing stack pops, moves, pushes and flushes
`default_nettype none
`include "second_greater_element_finder_core_assert.svh"
module sgef_ctrl
  import sgef_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  input  wire status_t sts,
  output cmd_t         cmd
);
  state_t state, state_next;
  logic   last_out;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // last result of flush: exactly one entry left across both stacks
  always_comb begin
    last_out = (sts.s2_empty && sts.s1_one) || (sts.s1_empty && sts.s2_one);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (in_valid) state_next = ST_S2_RD;
      ST_S2_RD:     begin
        if (sts.ovf) state_next = sts.last ? ST_FLUSH : ST_OVF;
        else if (sts.s2_empty) state_next = sts.hold_v ? ST_EMIT_HOLD : ST_S1_RD;
        else state_next = ST_S2_WT;
      end
      ST_S2_WT:     state_next = ST_S2_CMP;
      ST_S2_CMP:    begin
        if (sts.greater) state_next = ST_EMIT_RES;
        else state_next = sts.hold_v ? ST_EMIT_HOLD : ST_S1_RD;
      end
      ST_EMIT_RES:  if (!sts.hold_v || !sts.out_busy) state_next = ST_S2_RD;
      ST_EMIT_HOLD: if (!sts.out_busy) state_next = ST_S1_RD;
      ST_S1_RD:     state_next = sts.s1_empty ? ST_PUSH : ST_S1_WT;
      ST_S1_WT:     state_next = ST_S1_CMP;
      ST_S1_CMP:    state_next = sts.greater ? ST_S1_RD : ST_PUSH;
      ST_PUSH:      state_next = ST_MV_CHK;
      ST_MV_CHK:    state_next = sts.m_empty ? (sts.last ? ST_FLUSH : ST_IDLE) : ST_MOVE;
      ST_MOVE:      state_next = ST_MV_CHK;
      ST_FLUSH:     state_next = (sts.s2_empty && sts.s1_empty) ? ST_IDLE : ST_EMIT_FL;
      ST_EMIT_FL:   if (!sts.out_busy) state_next = ST_FLUSH;
      ST_OVF:       if (!sts.out_busy) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_IDLE:      cmd.load = in_valid;
      ST_S2_RD:     cmd.rd_s2 = 1'b1;
      ST_S2_WT:     cmd.rd_s2 = 1'b1;
      ST_S2_CMP:    cmd.rd_s2 = 1'b1;
      ST_EMIT_RES:  begin
        if (!sts.hold_v) begin
          cmd.pop_s2 = 1'b1;
        end else if (!sts.out_busy) begin
          cmd.out_load = 1'b1; cmd.out_found = 1'b1; cmd.pop_s2 = 1'b1;
        end
      end
      ST_EMIT_HOLD: if (!sts.out_busy) begin
        cmd.out_load = 1'b1; cmd.out_found = 1'b1; cmd.out_last = !sts.last;
      end
      ST_S1_RD:     cmd.rd_s1 = 1'b1;
      ST_S1_WT:     cmd.rd_s1 = 1'b1;
      ST_S1_CMP:    begin
        cmd.rd_s1 = 1'b1;
        cmd.pop_s1 = sts.greater;
      end
      ST_PUSH:      cmd.push_new = 1'b1;
      ST_MV_CHK:    cmd = '0;
      ST_MOVE:      cmd.move_one = 1'b1;
      ST_FLUSH:     begin
        cmd.rd_s2 = !sts.s2_empty;
        cmd.rd_s1 = sts.s2_empty;
        cmd.clear_count = sts.s2_empty && sts.s1_empty;
      end
      ST_EMIT_FL:   if (!sts.out_busy) begin
        cmd.out_load = 1'b1;
        cmd.flush_s2 = !sts.s2_empty;
        cmd.flush_s1 = sts.s2_empty;
        cmd.out_last = last_out;
      end
      ST_OVF:       if (!sts.out_busy) begin
        cmd.out_load = 1'b1; cmd.out_ovf_only = 1'b1; cmd.out_last = 1'b1;
      end
      default:      cmd = '0;
    endcase
  end

  `SGE_ASSERT_IMP(a_no_pop_empty, clk, rst, cmd.pop_s2 || cmd.flush_s2, !sts.s2_empty)
  `SGE_ASSERT_IMP(a_no_pop_s1_empty, clk, rst, cmd.pop_s1 || cmd.flush_s1, !sts.s1_empty)
  `SGE_ASSERT_NXT(a_out_busy, clk, rst, cmd.out_load, sts.out_busy)
endmodule
`default_nettype wire

// ===== rtl/core/second_greater_element_finder_core.sv =====
// Top level of the second greater element finder core
// Usage:
//   in_ch carries one sample per transaction with seq_end on the final one.
//   out_ch carries result transactions (position, answer, found, run_end,
//   seq_done, overflow); run_end marks the last result of an input item.
//   An item goes through accept, push and move check, plus a read per
//   stack whose scan reaches the bottom, a read, wait and compare per
//   entry compared, a pop per resolved entry, a send of the last resolved
//   result and a move and check per moved entry; the waits come from the
//   registered RAM reads. A dropped item without seq_end is taken and
//   reported. The flush sends each entry after a check, then checks again.
//   A new sample is taken once the controller is idle, even while a result
//   still waits in the output register.
//   Results sit in one output register; while the receiver stalls the
//   controller holds in the state that has the next result ready.
//   Reset empties both stacks and clears the item count; the stores are
//   not cleared and hold no meaning until written.
//   Items past capacity are dropped and reported with overflow set.
`default_nettype none
module second_greater_element_finder_core
  import sgef_pkg::*;
(
  input wire logic   clk,
  input wire logic   rst,
  sgef_in_if.sink    in_ch,
  sgef_out_if.source out_ch
);
  cmd_t    cmd;
  status_t sts;

  sgef_ctrl u_ctrl (.clk, .rst, .in_valid(in_ch.valid), .sts, .cmd);
  sgef_datapath u_dp (.clk, .rst, .cmd, .sts, .in_ch, .out_ch);
endmodule
`default_nettype wire

// ===== dv/second_greater_element_finder_core_test.sv =====
// Testbench for the second greater element finder core: directed table, overflow run, then random sequences
`timescale 1ns / 100ps
`default_nettype none
module second_greater_element_finder_core_test;
  import sgef_pkg::*;

  typedef struct packed {
    logic [5:0]         position;
    logic signed [31:0] answer;
    logic               found;
    logic               run_end;
    logic               seq_done;
    logic               overflow;
  } answer_t;

  typedef struct {
    logic signed [31:0] sample;
    logic               seq_end;
    bit                 typed;
    int                 n_typed;
    answer_t            typed_res[2];
  } stim_row_t;

  logic clk;
  logic rst;
  sgef_in_if  in_ch ();
  sgef_out_if out_ch ();

  second_greater_element_finder_core dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  logic signed [31:0] seen_val [MAX_LEN];
  int                 wait_first [$];
  int                 wait_second [$];
  int                 taken;
  answer_t            pending_answers [$];
  int                 fail_count;
  int                 send_idle;
  int                 recv_idle;
  longint             cycle_count;
  stim_row_t          table_rows [$];

  function automatic answer_t mk_ans(int p, logic signed [31:0] a, int f, int r, int d, int o);
    answer_t x;
    x.position = p[5:0];
    x.answer = a;
    x.found = f[0];
    x.run_end = r[0];
    x.seq_done = d[0];
    x.overflow = o[0];
    return x;
  endfunction

  function automatic void predict_second_greater(logic signed [31:0] v, bit last,
                                                 ref answer_t res [$]);
    bit ovf;
    int moved [$];
    int p;
    ovf = 0;
    res.delete();
    if (taken >= MAX_LEN) begin
      ovf = 1;
      if (!last) begin
        res = {res, mk_ans(0, 0, 0, 1, 0, 1)};
        return;
      end
    end else begin
      while (wait_second.size() > 0 && v > seen_val[wait_second[$]]) begin
        p = wait_second.pop_back();
        res = {res, mk_ans(p, v, 1, 0, 0, 0)};
      end
      while (wait_first.size() > 0 && v > seen_val[wait_first[$]])
        moved = {moved, wait_first.pop_back()};
      seen_val[taken] = v;
      wait_first = {wait_first, taken};
      taken++;
      while (moved.size() > 0)
        wait_second = {wait_second, moved.pop_back()};
    end
    if (last) begin
      while (wait_second.size() > 0)
        res = {res, mk_ans(wait_second.pop_back(), -1, 0, 0, 0, ovf)};
      while (wait_first.size() > 0)
        res = {res, mk_ans(wait_first.pop_back(), -1, 0, 0, 0, ovf)};
      taken = 0;
      if (res.size() > 0) res[$].seq_done = 1'b1;
    end
    if (res.size() > 0) res[$].run_end = 1'b1;
  endfunction

  task automatic send_sample(logic signed [31:0] v, bit last);
    answer_t res [$];
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.sample <= v;
    in_ch.seq_end <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_second_greater(v, last, res);
    foreach (res[i]) pending_answers = {pending_answers, res[i]};
  endtask

  function automatic logic signed [31:0] rand_sample();
    case ($urandom_range(5)) inside
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      [2:3]: return $signed($urandom_range(15)) - 8;
      default: return $signed($urandom);
    endcase
  endfunction

  task automatic send_random_sequence(output int len);
    len = ($urandom_range(9) == 0) ? $urandom_range(34, 40) : $urandom_range(1, 12);
    for (int i = 0; i < len; i++) send_sample(rand_sample(), i == len - 1);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_answers.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 2000000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) out_ch.ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    answer_t got;
    answer_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.position = out_ch.position;
      got.answer = out_ch.answer;
      got.found = out_ch.found;
      got.run_end = out_ch.run_end;
      got.seq_done = out_ch.seq_done;
      got.overflow = out_ch.overflow;
      if (pending_answers.size() == 0) begin
        $display("%0t unexpected result %p", $time, got);
        fail_count++;
      end else begin
        want = pending_answers.pop_front();
        if (got !== want) begin
          $display("%0t mismatch expected %p actual %p", $time, want, got);
          fail_count++;
        end
      end
    end
  end

  initial begin
    stim_row_t row;
    answer_t res [$];
    int seq_len;
    fail_count = 0;
    cycle_count = 0;
    taken = 0;
    send_idle = 31;
    recv_idle = 73;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.sample = '0;
    in_ch.seq_end = 1'b0;
    out_ch.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    row = '{sample: 0, seq_end: 1, typed: 1, n_typed: 1, typed_res: '{
            mk_ans(0, -1, 0, 1, 1, 0), mk_ans(0, 0, 0, 0, 0, 0)}};
    table_rows = {table_rows, row};
    row.typed = 0;
    row.n_typed = 0;
    foreach (row.typed_res[i]) row.typed_res[i] = '0;
    row.seq_end = 0; row.sample = 32'sh8000_0000; table_rows = {table_rows, row};
    row.sample = 32'sh8000_0000; table_rows = {table_rows, row};
    row.sample = -1; table_rows = {table_rows, row};
    row.sample = 5; table_rows = {table_rows, row};
    row.sample = 3; table_rows = {table_rows, row};
    row.sample = 4; table_rows = {table_rows, row};
    row.sample = 32'sh7fff_ffff; table_rows = {table_rows, row};
    row.sample = 32'sh7fff_ffff; table_rows = {table_rows, row};
    row.sample = 1; row.seq_end = 1; table_rows = {table_rows, row};
    row.seq_end = 0;
    for (int i = 0; i < 4; i++) begin
      row.sample = 10 - i; table_rows = {table_rows, row};
    end
    row.sample = 20; row.seq_end = 1; table_rows = {table_rows, row};

    foreach (table_rows[k]) begin
      if (table_rows[k].typed) begin
        predict_second_greater(table_rows[k].sample, table_rows[k].seq_end, res);
        for (int j = 0; j < table_rows[k].n_typed; j++)
          if (res.size() <= j || res[j] !== table_rows[k].typed_res[j]) begin
            $display("%0t predictor mismatch expected %p actual %p", $time,
                     table_rows[k].typed_res[j], res.size() > j ? res[j] : '0);
            fail_count++;
          end
        taken = 0;
        wait_first.delete();
        wait_second.delete();
      end
      send_sample(table_rows[k].sample, table_rows[k].seq_end);
    end

    for (int i = 0; i < MAX_LEN + 2; i++) send_sample(i, 1'b0);
    send_sample(-7, 1'b1);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 31 : (ph == 1) ? 73 : 0;
      recv_idle = (ph == 0) ? 73 : (ph == 1) ? 31 : 0;
      for (int cnt = 0; cnt < 135; ) begin
        send_random_sequence(seq_len);
        cnt += seq_len;
      end
      drain();
    end

    if (fail_count == 0 && pending_answers.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
